FILE: rtl/base64_stream_decoder_unit_defines.svh
// Assertion macros for the checker file of the base64 decoder.
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define B64D_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/b64d_pkg.sv
package b64d_pkg;

  // Character codes: 0-63 are data, then padding and invalid.
  localparam logic [6:0] CODE_PAD     = 7'd64;
  localparam logic [6:0] CODE_INVALID = 7'd65;

  // Result status codes.
  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_BADCHAR = 2'd1;
  localparam logic [1:0] ST_BADLEN  = 2'd2;

  // One queued command: up to three bytes to send, in order.
  typedef struct packed {
    logic [7:0] slot0;
    logic [7:0] slot1;
    logic [7:0] slot2;
    logic [1:0] count;
    logic [1:0] status;
    logic       fin;
  } cmd_t;

  // Map an ASCII character to its 7-bit base64 code.
  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [6:0] code;
    code = CODE_INVALID;
    if (c >= 8'h41 && c <= 8'h5a) begin
      code = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      code = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      code = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      code = 7'd62;
    end else if (c == 8'h2f) begin
      code = 7'd63;
    end else if (c == 8'h3d) begin
      code = CODE_PAD;
    end
    return code;
  endfunction

endpackage

FILE: rtl/b64d_if.sv
// Character channel into the decoder.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_final;

  modport source (output valid, output ch, output is_final, input ready);
  modport sink   (input valid, input ch, input is_final, output ready);
endinterface

// Byte channel out of the decoder.
interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       end_of_message;

  modport source (output valid, output data_byte, output status, output end_of_message,
                  input ready);
  modport sink   (input valid, input data_byte, input status, input end_of_message,
                  output ready);
endinterface

FILE: rtl/b64d_front.sv
// Front end: classifies each character, collects quartets and queues commands.
module b64d_front (
  input  logic             clk,
  input  logic             rst,
  b64d_char_if.sink        char_in,
  input  logic             full,
  output logic             push,
  output b64d_pkg::cmd_t   cmd
);

  logic [1:0] qpos, qpos_next;
  logic [6:0] held [3];
  logic [6:0] held_next [3];
  logic       skipping, skipping_next;
  logic       accept;
  logic [6:0] code;
  logic [7:0] b1, b2, b3;
  logic       send2, send3;

  assign char_in.ready = !full;
  assign accept        = char_in.valid && char_in.ready;
  assign code          = b64d_pkg::map_char(char_in.ch);

  // Bytes of a completed quartet, truncated to eight bits.
  assign b1    = {held[0][5:0], 2'b00} | {5'b0, held[1][6:4]};
  assign b2    = {held[1][3:0], 4'b0000} | {3'b0, held[2][6:2]};
  assign b3    = {held[2][1:0], 6'b0} | {1'b0, code};
  assign send2 = (held[2] != b64d_pkg::CODE_PAD);
  assign send3 = (code != b64d_pkg::CODE_PAD);

  // Next state and the command for the queue.
  always_comb begin
    qpos_next     = qpos;
    held_next     = held;
    skipping_next = skipping;
    push          = 1'b0;
    cmd           = '0;
    if (accept) begin
      if (skipping) begin
        if (char_in.is_final) begin
          skipping_next = 1'b0;
          qpos_next     = '0;
          held_next     = '{default: '0};
        end
      end else if (code == b64d_pkg::CODE_INVALID) begin
        push          = 1'b1;
        cmd.count     = 2'd1;
        cmd.status    = b64d_pkg::ST_BADCHAR;
        cmd.fin       = 1'b1;
        qpos_next     = '0;
        held_next     = '{default: '0};
        skipping_next = !char_in.is_final;
      end else if (qpos != 2'd3) begin
        held_next[qpos] = code;
        qpos_next       = qpos + 2'd1;
        if (char_in.is_final) begin
          push       = 1'b1;
          cmd.count  = 2'd1;
          cmd.status = b64d_pkg::ST_BADLEN;
          cmd.fin    = 1'b1;
          qpos_next  = '0;
          held_next  = '{default: '0};
        end
      end else begin
        push       = 1'b1;
        cmd.slot0  = b1;
        cmd.slot1  = send2 ? b2 : b3;
        cmd.slot2  = b3;
        cmd.count  = 2'd1 + {1'b0, send2} + {1'b0, send3};
        cmd.status = b64d_pkg::ST_DATA;
        cmd.fin    = char_in.is_final;
        qpos_next  = '0;
        held_next  = '{default: '0};
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      qpos     <= '0;
      held     <= '{default: '0};
      skipping <= 1'b0;
    end else begin
      qpos     <= qpos_next;
      held     <= held_next;
      skipping <= skipping_next;
    end
  end

endmodule

FILE: rtl/b64d_queue.sv
// Short command queue between the front and back ends.
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64d_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output b64d_pkg::cmd_t head,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  b64d_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push, do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: rtl/b64d_back.sv
// Back end: sends each command's bytes, one item per cycle while ready.
module b64d_back (
  input  logic           clk,
  input  logic           rst,
  input  b64d_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  b64d_byte_if.source    byte_out
);

  logic [1:0] idx;
  logic       load;
  logic       last;
  logic [7:0] sel_byte;

  assign load = !byte_out.valid || byte_out.ready;
  assign last = (idx == head.count - 2'd1);
  assign pop  = load && !empty && last;

  // Pick the byte for the current slot.
  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.slot0;
      2'd1:    sel_byte = head.slot1;
      default: sel_byte = head.slot2;
    endcase
  end

  // Output register and slot counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_out.valid <= 1'b0;
      idx            <= '0;
    end else if (load) begin
      byte_out.valid <= !empty;
      if (!empty) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      byte_out.data_byte      <= sel_byte;
      byte_out.status         <= head.status;
      byte_out.end_of_message <= head.fin && last;
    end
  end

endmodule

FILE: rtl/base64_stream_decoder_unit.sv
// Channel     Dir   Payload                                   Handshake
// char_in     in    ch[7:0], is_final                         valid / ready
// byte_out    out   data_byte[7:0], status[1:0], end_of_message  valid / ready
//
// One character is taken per cycle while the queue has room; a full quartet
// yields up to three bytes, sent one per cycle from a registered output while
// the output is ready; the bytes pass through the command queue first.
// The front end stalls only when the command queue (QUEUE_DEPTH entries) is full.
// Reset clears the quartet, the skip flag, the queue and the output valid flag.
module base64_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  b64d_char_if.sink    char_in,
  b64d_byte_if.source  byte_out
);

  b64d_pkg::cmd_t push_cmd, head;
  logic           push, full, pop, empty;

  b64d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .full    (full),
    .push    (push),
    .cmd     (push_cmd)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .byte_out (byte_out)
  );

endmodule

FILE: rtl/b64d_checker.sv
`include "base64_stream_decoder_unit_defines.svh"

// Port-level checks on the decoder's result stream.
module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_status,
  input logic       out_end
);

  `B64D_ASSERT_NOW(a_status_range, clk, rst, out_valid, out_status != 2'd3, "status out of range")

  `B64D_ASSERT_NOW(a_error_zero, clk, rst, out_valid && (out_status != b64d_pkg::ST_DATA), (out_byte == 8'd0) && out_end, "error item not zero or not final")

  `B64D_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_status) && $stable(out_end), "stalled item changed")

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (byte_out.valid),
  .out_ready  (byte_out.ready),
  .out_byte   (byte_out.data_byte),
  .out_status (byte_out.status),
  .out_end    (byte_out.end_of_message)
);

FILE: tb/b64d_decode_checker.sv
// Watches both channels of the decoder, predicts the bytes each accepted
// character produces and compares them, in order, with the bytes that come out.
module b64d_decode_checker (
  input  logic clk,
  input  logic rst,
  b64d_char_if chars,
  b64d_byte_if bytes,
  output int   failures,
  output int   pending,
  output int   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       eom;
  } decoded_t;

  // Bytes predicted but not yet seen on the output, oldest first.
  decoded_t expected_bytes[$];

  // Predictor state: position in the quartet, the held codes, the skip flag.
  logic [1:0] quartet_pos;
  logic [6:0] held[3];
  logic       skipping;

  initial begin
    failures = 0;
    checked  = 0;
  end

  // Translate an ASCII character into its 7-bit alphabet code.
  function automatic logic [6:0] code_of(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return 7'(c - 8'h41);
    end
    if (c >= 8'h61 && c <= 8'h7a) begin
      return 7'(c - 8'h61 + 8'd26);
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      return 7'(c - 8'h30 + 8'd52);
    end
    if (c == 8'h2b) begin
      return 7'd62;
    end
    if (c == 8'h2f) begin
      return 7'd63;
    end
    if (c == 8'h3d) begin
      return b64d_pkg::CODE_PAD;
    end
    return b64d_pkg::CODE_INVALID;
  endfunction

  // Append one predicted item at the tail of the queue.
  function automatic void add_expected(input decoded_t item);
    expected_bytes = {expected_bytes, item};
  endfunction

  task automatic clear_quartet();
    quartet_pos = 2'd0;
    held = '{default: '0};
  endtask

  // Advance the predictor by one character and queue the bytes it yields.
  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [6:0]  code;
    logic [31:0] w0, w1, w2, w3;
    logic        send2, send3;
    decoded_t    r;

    // After an error everything is dropped up to the end of the message.
    if (skipping) begin
      if (fin) begin
        skipping = 1'b0;
        clear_quartet();
      end
      return;
    end

    code = code_of(c);
    if (code == b64d_pkg::CODE_INVALID) begin
      r = '{8'd0, b64d_pkg::ST_BADCHAR, 1'b1};
      add_expected(r);
      clear_quartet();
      skipping = !fin;
      return;
    end

    // The first three characters are only held; an end here is a bad length.
    if (quartet_pos < 2'd3) begin
      held[quartet_pos] = code;
      quartet_pos = quartet_pos + 2'd1;
      if (fin) begin
        r = '{8'd0, b64d_pkg::ST_BADLEN, 1'b1};
        add_expected(r);
        clear_quartet();
      end
      return;
    end

    // The fourth character completes the quartet. Padding codes take part in
    // the arithmetic, so wider values spill into neighboring bits.
    w0 = 32'(held[0]);
    w1 = 32'(held[1]);
    w2 = 32'(held[2]);
    w3 = 32'(code);
    clear_quartet();
    send2 = (w2 != 32'(b64d_pkg::CODE_PAD));
    send3 = (code != b64d_pkg::CODE_PAD);

    r = '{8'((w0 << 2) | (w1 >> 4)), b64d_pkg::ST_DATA, fin && !send2 && !send3};
    add_expected(r);
    if (send2) begin
      r = '{8'(((w1 & 32'h0f) << 4) | (w2 >> 2)), b64d_pkg::ST_DATA, fin && !send3};
      add_expected(r);
    end
    if (send3) begin
      r = '{8'(((w2 & 32'h03) << 6) | w3), b64d_pkg::ST_DATA, fin};
      add_expected(r);
    end
  endtask

  // Predict on accepted characters, compare on accepted bytes.
  always @(posedge clk) begin
    decoded_t got, want;
    if (rst) begin
      clear_quartet();
      skipping = 1'b0;
      expected_bytes.delete();
    end else begin
      if (chars.valid && chars.ready) begin
        decode_char(chars.ch, chars.is_final);
      end
      if (bytes.valid && bytes.ready) begin
        got = '{bytes.data_byte, bytes.status, bytes.end_of_message};
        checked++;
        if (expected_bytes.size() == 0) begin
          $error("unexpected item: data_byte 8'h%02h status %0d end_of_message %0b",
                 got.data_byte, got.status, got.eom);
          failures++;
        end else begin
          want = expected_bytes.pop_front();
          if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected 8'h%02h, got 8'h%02h", want.data_byte, got.data_byte);
            failures++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
          end
          if (got.eom !== want.eom) begin
            $error("end_of_message: expected %0b, got %0b", want.eom, got.eom);
            failures++;
          end
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

FILE: tb/testbench.sv
// Drives characters into the decoder and stalls its output at random; the
// checker instance beside the block does all prediction and comparison.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 96;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;
  logic steady;
  int   failures;
  int   pending;
  int   checked;
  int   quiet_cycles;
  int   sent_chars;
  int   sent_msgs;
  int   random_chars;

  b64d_char_if char_ch ();
  b64d_byte_if byte_ch ();

  base64_stream_decoder_unit uut (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_ch),
    .byte_out (byte_ch)
  );

  b64d_decode_checker byte_check (
    .clk      (clk),
    .rst      (rst),
    .chars    (char_ch),
    .bytes    (byte_ch),
    .failures (failures),
    .pending  (pending),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side: stall on about 31 percent of clocks unless in a steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.ready <= 1'b0;
    end else begin
      byte_ch.ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (char_ch.valid && char_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Character with the given alphabet index; index 64 is the padding sign.
  function automatic logic [7:0] b64_symbol(input int idx);
    if (idx < 26) begin
      return 8'(8'h41 + idx);
    end
    if (idx < 52) begin
      return 8'(8'h61 + idx - 26);
    end
    if (idx < 62) begin
      return 8'(8'h30 + idx - 52);
    end
    if (idx == 62) begin
      return 8'h2b;
    end
    if (idx == 63) begin
      return 8'h2f;
    end
    return 8'h3d;
  endfunction

  // Offer one character, idling at random first, and wait until it is taken.
  task automatic send_char(input logic [7:0] c, input logic fin);
    logic took;
    while (!steady && $urandom_range(99) < 31) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid    <= 1'b1;
    char_ch.ch       <= c;
    char_ch.is_final <= fin;
    do begin
      @(negedge clk);
      took = char_ch.ready;
      @(posedge clk);
    end while (!took);
    sent_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
    sent_msgs++;
  endtask

  // Hold the input idle until every predicted byte has come out.
  task automatic wait_drained();
    char_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Mostly well-formed messages with random padding; the rest are broken
  // messages with stray characters, and pure noise with early ends.
  task automatic random_message();
    int         kind;
    int         nq;
    int         pad;
    int         len;
    logic [7:0] c;
    logic       fin;
    kind = $urandom_range(99);
    if (kind < 80) begin
      nq  = $urandom_range(1, 4);
      pad = $urandom_range(0, 2);
      for (int i = 0; i < nq * 4; i++) begin
        c = (i >= nq * 4 - pad) ? 8'h3d : b64_symbol($urandom_range(63));
        send_char(c, i == nq * 4 - 1);
      end
    end else begin
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        if (kind < 90 && $urandom_range(3) != 0) begin
          c = b64_symbol($urandom_range(64));
        end else begin
          c = 8'($urandom_range(255));
        end
        fin = (i == len - 1) || (kind >= 90 && $urandom_range(7) == 0);
        send_char(c, fin);
      end
    end
    sent_msgs++;
  endtask

  // Stimulus and verdict.
  initial begin
    int start;
    rst              <= 1'b1;
    steady           <= 1'b0;
    char_ch.valid    <= 1'b0;
    char_ch.ch       <= 8'h00;
    char_ch.is_final <= 1'b0;
    sent_chars   = 0;
    sent_msgs    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: one and two pad signs, the alphabet's extremes, a bad
    // character followed by skipped input, a short ending, padding in the
    // early positions, and a bad character as the very last one.
    send_text("TWE=");
    send_text("TQ==");
    send_text("AZaz09+/");
    send_char(8'h41, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    sent_msgs++;
    send_text("AB");
    send_text("=A=z");
    send_char(8'h00, 1'b1);
    sent_msgs++;
    wait_drained();

    // Random messages, with a stretch free of idling and periodic drains.
    start = sent_chars;
    for (int m = 0; sent_chars - start < RANDOM_ITEMS; m++) begin
      steady <= (m >= 6 && m < 12);
      random_message();
      if (m % 12 == 5) begin
        wait_drained();
      end
    end
    random_chars = sent_chars - start;
    steady <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d messages (%0d random); compared %0d output items.",
             sent_chars, sent_msgs, random_chars, checked);
    $display("Covered padding, bad characters, short endings, skipping and output stalls.");
    if (failures == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
